@@ design/lepm_pkg.sv @@
// shared types, codes and helpers for the local extrema plateau marker
package lepm_pkg;

    localparam int unsigned DEF_MAX_WIDTH  = 64;
    localparam int unsigned DEF_MAX_HEIGHT = 64;
    localparam int unsigned CFG_DATA_W     = 8;
    localparam int unsigned CFG_INDEX_W    = 2;
    localparam int unsigned DIM_FIELD_W    = 7;
    localparam int unsigned DIM_CALC_W     = 11;
    localparam logic [7:0]  FG_RESET       = 8'd255;
    localparam logic [7:0]  BG_RESET       = 8'd0;
    localparam logic [6:0]  DIM_RESET      = 7'd64;

    typedef enum logic [1:0] {
        REG_WIDTH  = 2'd0,
        REG_HEIGHT = 2'd1,
        REG_FG     = 2'd2,
        REG_BG     = 2'd3
    } t_reg_index;

    typedef enum logic [3:0] {
        S_LOAD,
        S_READ,
        S_SCAN,
        S_SCAN_W,
        S_NB_ISSUE,
        S_NB_EVAL,
        S_POP,
        S_POP_W,
        S_FILL_ISSUE,
        S_FILL_EVAL
    } t_state;

    // one step along an axis toward a neighbor
    typedef enum logic [1:0] {
        STEP_ZERO  = 2'd0,
        STEP_PLUS  = 2'd1,
        STEP_MINUS = 2'd2
    } t_step;

    localparam logic [2:0] NB_FIRST = 3'd0;
    localparam logic [2:0] NB_LAST  = 3'd7;

    // column step of neighbor code nb
    function automatic t_step nb_dx(input logic [2:0] nb);
        t_step s;
        unique case (nb)
            3'd0, 3'd3, 3'd5: s = STEP_MINUS;
            3'd1, 3'd6:       s = STEP_ZERO;
            default:          s = STEP_PLUS;
        endcase
        return s;
    endfunction

    // row step of neighbor code nb
    function automatic t_step nb_dy(input logic [2:0] nb);
        t_step s;
        unique case (nb)
            3'd0, 3'd1, 3'd2: s = STEP_MINUS;
            3'd3, 3'd4:       s = STEP_ZERO;
            default:          s = STEP_PLUS;
        endcase
        return s;
    endfunction

    // a dimension of 0 counts as 1, any value above the maximum as the maximum
    function automatic logic [DIM_CALC_W-1:0] clamp_dim(input logic [DIM_FIELD_W-1:0] v,
                                                        input logic [DIM_CALC_W-1:0] maxv);
        logic [DIM_CALC_W-1:0] e;
        e = DIM_CALC_W'(v);
        if (e == '0) begin
            return DIM_CALC_W'(1);
        end
        if (e > maxv) begin
            return maxv;
        end
        return e;
    endfunction

endpackage

@@ design/local_extrema_plateau_marker.sv @@
// top level of the local extrema plateau marker: loader, extremum scan, plateau fill, readout
//
// Usage: load an image of image_width x image_height bytes in raster order, one pixel per
// request with i_func = 0. After the last pixel the block raises busy and scans the image:
// a pixel already cleared only gets its mark check; a candidate gets that check and then a
// read of each in-image neighbor, a neighbor outside the image being only stepped over, and
// every pixel cleared by a plateau fill gets a stack pop plus the same per-neighbor work,
// with a final empty pop ending each fill. All of this is bound by the single read port of
// the image memory. Loads and readout requests (i_func = 1) are taken every cycle while busy
// is low; each readout request gives one mark on the cycle after it, flagged by o_valid for
// that one cycle only, so the receiver has to take it then. A readout request while loading
// is dropped, a load during readout abandons the readout and starts a new image. Writing a
// dimension register restarts loading. No clearing pass is needed after reset.
module local_extrema_plateau_marker #(
    parameter int unsigned MAX_WIDTH  = lepm_pkg::DEF_MAX_WIDTH,
    parameter int unsigned MAX_HEIGHT = lepm_pkg::DEF_MAX_HEIGHT
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                i_func,
    input  logic [7:0]                          i_pixel_value,
    input  logic                                i_cfg_we,
    input  logic [lepm_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [lepm_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output logic                                o_valid,
    output logic [7:0]                          o_mark_value,
    output logic                                o_last_of_image,
    output logic                                o_config_error
);
    import lepm_pkg::*;

    localparam int unsigned MAX_PIXELS = MAX_WIDTH * MAX_HEIGHT;
    localparam int unsigned AW  = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
    localparam int unsigned PCW = $clog2(MAX_PIXELS + 1);
    localparam int unsigned XW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int unsigned YW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int unsigned WW  = $clog2(MAX_WIDTH + 1);
    localparam int unsigned HW  = $clog2(MAX_HEIGHT + 1);
    localparam int unsigned SW  = XW + YW;
    localparam logic [DIM_CALC_W-1:0] MAXW_C = DIM_CALC_W'(MAX_WIDTH);
    localparam logic [DIM_CALC_W-1:0] MAXH_C = DIM_CALC_W'(MAX_HEIGHT);

    // configuration
    logic [WW-1:0] r_w;
    logic [HW-1:0] r_h;
    logic [7:0]    r_fg, r_bg;

    // control
    t_state         r_state, n_state;
    logic [PCW-1:0] r_load_count, n_load_count;
    logic [PCW-1:0] r_read_count, n_read_count;
    logic [AW-1:0]  r_sidx, n_sidx;
    logic [XW-1:0]  r_sx, n_sx, r_cx, n_cx;
    logic [YW-1:0]  r_sy, n_sy, r_cy, n_cy;
    logic [2:0]     r_nb, n_nb;
    logic [7:0]     r_level, n_level;
    logic           r_larger, n_larger, r_smaller, n_smaller;
    logic [PCW-1:0] r_sp, n_sp;
    logic [AW-1:0]  r_naddr, n_naddr;
    logic           r_out_v, n_out_v;
    logic           r_out_last, n_out_last;
    logic           r_out_err, n_out_err;

    // memories and their registered read data
    logic [7:0]    image_mem [MAX_PIXELS];
    logic          mark_mem  [MAX_PIXELS];
    logic [SW-1:0] stack_mem [MAX_PIXELS];
    logic [7:0]    r_img_q;
    logic          r_mark_q;
    logic [SW-1:0] r_stk_q;

    logic          c_img_we, c_mark_we, c_mark_wd, c_stk_we;
    logic [AW-1:0] c_img_wa, c_img_ra, c_mark_wa, c_mark_ra, c_stk_wa, c_stk_ra;
    logic [SW-1:0] c_stk_wd;

    // derived values
    logic [PCW-1:0] c_npix;
    logic           c_req, c_load_req, c_read_req;
    logic           c_xok, c_yok, c_nb_ok;
    logic [XW-1:0]  c_nx;
    logic [YW-1:0]  c_ny;
    logic [AW-1:0]  c_naddr;
    logic [PCW-1:0] c_lc;
    logic           c_scan_last;

    assign c_npix     = PCW'(r_w) * PCW'(r_h);
    assign busy       = !(r_state == S_LOAD || r_state == S_READ);
    assign c_req      = start && !busy;
    assign c_load_req = c_req && !i_func;
    assign c_read_req = c_req && i_func && (r_state == S_READ);
    // a load during readout starts a new image at pixel zero
    assign c_lc       = (r_state == S_READ) ? '0 : r_load_count;
    assign c_scan_last = (PCW'(r_sidx) + PCW'(1)) == c_npix;

    // neighbor of the current center (r_cx, r_cy) selected by r_nb, with its bounds check
    always_comb begin
        c_xok = 1'b1;
        c_nx  = r_cx;
        case (nb_dx(r_nb))
            STEP_PLUS: begin
                c_xok = (WW'(r_cx) + WW'(1)) < r_w;
                c_nx  = r_cx + XW'(1);
            end
            STEP_MINUS: begin
                c_xok = (r_cx != '0);
                c_nx  = r_cx - XW'(1);
            end
            default: begin
                c_xok = 1'b1;
                c_nx  = r_cx;
            end
        endcase
        c_yok = 1'b1;
        c_ny  = r_cy;
        case (nb_dy(r_nb))
            STEP_PLUS: begin
                c_yok = (HW'(r_cy) + HW'(1)) < r_h;
                c_ny  = r_cy + YW'(1);
            end
            STEP_MINUS: begin
                c_yok = (r_cy != '0);
                c_ny  = r_cy - YW'(1);
            end
            default: begin
                c_yok = 1'b1;
                c_ny  = r_cy;
            end
        endcase
        c_nb_ok = c_xok && c_yok;
        c_naddr = AW'(c_ny) * AW'(r_w) + AW'(c_nx);
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w  <= WW'(clamp_dim(DIM_RESET, MAXW_C));
            r_h  <= HW'(clamp_dim(DIM_RESET, MAXH_C));
            r_fg <= FG_RESET;
            r_bg <= BG_RESET;
        end else if (i_cfg_we) begin
            unique case (t_reg_index'(i_cfg_index))
                REG_WIDTH:  r_w  <= WW'(clamp_dim(i_cfg_data[DIM_FIELD_W-1:0], MAXW_C));
                REG_HEIGHT: r_h  <= HW'(clamp_dim(i_cfg_data[DIM_FIELD_W-1:0], MAXH_C));
                REG_FG:     r_fg <= i_cfg_data;
                REG_BG:     r_bg <= i_cfg_data;
                default:    r_fg <= r_fg;
            endcase
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_LOAD;
            r_load_count <= '0;
            r_read_count <= '0;
            r_sp         <= '0;
            r_out_v      <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_load_count <= n_load_count;
            r_read_count <= n_read_count;
            r_sp         <= n_sp;
            r_out_v      <= n_out_v;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_sidx     <= n_sidx;
        r_sx       <= n_sx;
        r_sy       <= n_sy;
        r_cx       <= n_cx;
        r_cy       <= n_cy;
        r_nb       <= n_nb;
        r_level    <= n_level;
        r_larger   <= n_larger;
        r_smaller  <= n_smaller;
        r_naddr    <= n_naddr;
        r_out_last <= n_out_last;
        r_out_err  <= n_out_err;
    end

    // memories, one write and one read port each, read data registered
    always_ff @(posedge i_clk) begin
        if (c_img_we) begin
            image_mem[c_img_wa] <= i_pixel_value;
        end
        r_img_q <= image_mem[c_img_ra];
    end

    always_ff @(posedge i_clk) begin
        if (c_mark_we) begin
            mark_mem[c_mark_wa] <= c_mark_wd;
        end
        r_mark_q <= mark_mem[c_mark_ra];
    end

    always_ff @(posedge i_clk) begin
        if (c_stk_we) begin
            stack_mem[c_stk_wa] <= c_stk_wd;
        end
        r_stk_q <= stack_mem[c_stk_ra];
    end

    // sequencer
    always_comb begin
        n_state      = r_state;
        n_load_count = r_load_count;
        n_read_count = r_read_count;
        n_sidx       = r_sidx;
        n_sx         = r_sx;
        n_sy         = r_sy;
        n_cx         = r_cx;
        n_cy         = r_cy;
        n_nb         = r_nb;
        n_level      = r_level;
        n_larger     = r_larger;
        n_smaller    = r_smaller;
        n_sp         = r_sp;
        n_naddr      = r_naddr;
        n_out_v      = 1'b0;
        n_out_last   = r_out_last;
        n_out_err    = r_out_err;

        c_img_we  = 1'b0;
        c_img_wa  = c_lc[AW-1:0];
        c_img_ra  = r_sidx;
        c_mark_we = 1'b0;
        c_mark_wa = c_lc[AW-1:0];
        c_mark_wd = 1'b1;
        c_mark_ra = r_sidx;
        c_stk_we  = 1'b0;
        c_stk_wa  = r_sp[AW-1:0];
        c_stk_wd  = {c_ny, c_nx};
        c_stk_ra  = r_sp[AW-1:0] - AW'(1);

        unique case (r_state)
            S_LOAD, S_READ: begin
                c_mark_ra = r_read_count[AW-1:0];
                if (c_load_req) begin
                    // loading also sets the candidate mark of the pixel
                    c_img_we     = 1'b1;
                    c_mark_we    = 1'b1;
                    n_read_count = '0;
                    n_load_count = c_lc + PCW'(1);
                    if ((c_lc + PCW'(1)) >= c_npix) begin
                        n_state      = S_SCAN;
                        n_load_count = '0;
                        n_sidx       = '0;
                        n_sx         = '0;
                        n_sy         = '0;
                    end else begin
                        n_state = S_LOAD;
                    end
                end else if (c_read_req) begin
                    n_out_v      = 1'b1;
                    n_out_last   = (r_read_count + PCW'(1)) >= c_npix;
                    n_out_err    = (r_fg == r_bg);
                    n_read_count = r_read_count + PCW'(1);
                    if ((r_read_count + PCW'(1)) >= c_npix) begin
                        n_state      = S_LOAD;
                        n_read_count = '0;
                    end
                end
            end
            S_SCAN: begin
                // mark and center value of the scan pixel
                c_mark_ra = r_sidx;
                c_img_ra  = r_sidx;
                n_state   = S_SCAN_W;
            end
            S_SCAN_W: begin
                if (r_mark_q) begin
                    n_level   = r_img_q;
                    n_larger  = 1'b0;
                    n_smaller = 1'b0;
                    n_nb      = NB_FIRST;
                    n_cx      = r_sx;
                    n_cy      = r_sy;
                    n_state   = S_NB_ISSUE;
                end else if (c_scan_last) begin
                    n_state = S_READ;
                end else begin
                    n_sidx  = r_sidx + AW'(1);
                    n_state = S_SCAN;
                    if ((WW'(r_sx) + WW'(1)) == r_w) begin
                        n_sx = '0;
                        n_sy = r_sy + YW'(1);
                    end else begin
                        n_sx = r_sx + XW'(1);
                    end
                end
            end
            S_NB_ISSUE: begin
                c_img_ra = c_naddr;
                if (c_nb_ok) begin
                    n_state = S_NB_EVAL;
                end else if (r_nb == NB_LAST) begin
                    n_state = S_NB_EVAL;
                end else begin
                    n_nb = r_nb + 3'd1;
                end
            end
            S_NB_EVAL: begin
                // skipped last neighbor falls through without a compare
                if (c_nb_ok) begin
                    if (r_img_q > r_level) begin
                        n_larger = 1'b1;
                    end else if (r_img_q < r_level) begin
                        n_smaller = 1'b1;
                    end
                end
                if (r_nb != NB_LAST) begin
                    n_nb    = r_nb + 3'd1;
                    n_state = S_NB_ISSUE;
                end else if ((n_larger && n_smaller)) begin
                    // clear the scan pixel and push it as the fill seed
                    c_mark_we = 1'b1;
                    c_mark_wa = r_sidx;
                    c_mark_wd = 1'b0;
                    c_stk_we  = 1'b1;
                    c_stk_wa  = '0;
                    c_stk_wd  = {r_sy, r_sx};
                    n_sp      = PCW'(1);
                    n_state   = S_POP;
                end else if (c_scan_last) begin
                    n_state = S_READ;
                end else begin
                    n_sidx  = r_sidx + AW'(1);
                    n_state = S_SCAN;
                    if ((WW'(r_sx) + WW'(1)) == r_w) begin
                        n_sx = '0;
                        n_sy = r_sy + YW'(1);
                    end else begin
                        n_sx = r_sx + XW'(1);
                    end
                end
            end
            S_POP: begin
                if (r_sp == '0) begin
                    if (c_scan_last) begin
                        n_state = S_READ;
                    end else begin
                        n_sidx  = r_sidx + AW'(1);
                        n_state = S_SCAN;
                        if ((WW'(r_sx) + WW'(1)) == r_w) begin
                            n_sx = '0;
                            n_sy = r_sy + YW'(1);
                        end else begin
                            n_sx = r_sx + XW'(1);
                        end
                    end
                end else begin
                    n_sp    = r_sp - PCW'(1);
                    n_state = S_POP_W;
                end
            end
            S_POP_W: begin
                n_cy    = r_stk_q[SW-1:XW];
                n_cx    = r_stk_q[XW-1:0];
                n_nb    = NB_FIRST;
                n_state = S_FILL_ISSUE;
            end
            S_FILL_ISSUE: begin
                c_img_ra  = c_naddr;
                c_mark_ra = c_naddr;
                n_naddr   = c_naddr;
                if (c_nb_ok) begin
                    n_state = S_FILL_EVAL;
                end else if (r_nb == NB_LAST) begin
                    n_state = S_POP;
                end else begin
                    n_nb = r_nb + 3'd1;
                end
            end
            S_FILL_EVAL: begin
                // same-level neighbor still marked joins the plateau
                if (r_mark_q && (r_img_q == r_level)) begin
                    c_mark_we = 1'b1;
                    c_mark_wa = r_naddr;
                    c_mark_wd = 1'b0;
                    c_stk_we  = 1'b1;
                    c_stk_wa  = r_sp[AW-1:0];
                    c_stk_wd  = {c_ny, c_nx};
                    n_sp      = r_sp + PCW'(1);
                end
                if (r_nb == NB_LAST) begin
                    n_state = S_POP;
                end else begin
                    n_nb    = r_nb + 3'd1;
                    n_state = S_FILL_ISSUE;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase

        // a dimension write abandons the current image
        if (i_cfg_we && (t_reg_index'(i_cfg_index) == REG_WIDTH ||
                         t_reg_index'(i_cfg_index) == REG_HEIGHT)) begin
            n_state      = S_LOAD;
            n_load_count = '0;
            n_read_count = '0;
            n_sp         = '0;
        end
    end

    // result ports
    assign o_valid         = r_out_v;
    assign o_last_of_image = r_out_last;
    assign o_config_error  = r_out_err;
    assign o_mark_value    = r_out_err ? 8'd0 : (r_mark_q ? r_fg : r_bg);

    // a mark only follows an accepted readout request
    a_valid_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy && i_func))
        else $error("mark without readout request");

    // the fill stack never holds more entries than pixels
    a_stack_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sp <= PCW'(MAX_PIXELS))
        else $error("fill stack overflow");

    // the load counter stays below the pixel count while loading
    a_load_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOAD) |-> (r_load_count < c_npix))
        else $error("load count past image end");

    // a fill pop is always preceded by a non-empty stack
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_POP_W) |-> $past(r_sp != '0))
        else $error("pop from empty stack");

endmodule
